>>> sv/assert_macros.svh
// Assertion macros shared by the rename and reorder buffer RTL.
// No dependencies; SYNTH empties the bodies for synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

>>> sv/rrob_pkg.sv
// Shared constants, codes and types for the rename and reorder buffer block.
// No dependencies.
package rrob_pkg;

    localparam int ROB_ENTRIES = 64;
    localparam int ARCH_REGS   = 67;
    localparam int TAG_W       = $clog2(ROB_ENTRIES);
    localparam int RIDX_W      = $clog2(ARCH_REGS);
    localparam int OCC_W       = $clog2(ROB_ENTRIES + 1);
    localparam int SUM_W       = ((OCC_W > 4) ? OCC_W : 4) + 1;

    localparam logic [3:0] BW_RESET = 4'd4;

    localparam logic [1:0] ACT_RENAME   = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_RETIRE   = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    localparam logic [2:0] ST_RENAMED   = 3'd0;
    localparam logic [2:0] ST_STALLED   = 3'd1;
    localparam logic [2:0] ST_COMPLETED = 3'd2;
    localparam logic [2:0] ST_RETIRED   = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    typedef struct packed {
        logic [1:0]        action;
        logic              bundle_start;
        logic [31:0]       seq_number;
        logic signed [7:0] dest_reg;
        logic signed [7:0] src_a_reg;
        logic signed [7:0] src_b_reg;
        logic [5:0]        done_tag;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        slot_tag;
        logic              src_a_ready;
        logic signed [7:0] src_a_name;
        logic              src_b_ready;
        logic signed [7:0] src_b_name;
        logic signed [7:0] done_dest;
        logic [31:0]       retired_seq;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic cmp;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       out_free;
    } dp_stat_t;

    function automatic logic reg_in_range(input logic [7:0] r);
        return (r[7] == 1'b0) && ({1'b0, r} < 9'(ARCH_REGS));
    endfunction

endpackage

>>> sv/rrob_ctrl.sv
// Sequencer for the rename and reorder buffer block.
// Depends on rrob_pkg; drives datapath commands from its status.
module rrob_ctrl
    import rrob_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // hold off requests while in reset
    assign s_tready = aresetn && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
                // an unused action code is dropped here without a result
                if (s_tvalid && (stat.action == ACT_RENAME || stat.action == ACT_COMPLETE
                                 || stat.action == ACT_RETIRE)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = (stat.action == ACT_COMPLETE) ? S_CMP : S_OUT;
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.emit = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/rrob_dp.sv
// Datapath: rename map, reorder buffer stores, pointers and result registers.
// Depends on rrob_pkg and assert_macros.svh; commanded by rrob_ctrl.
`include "assert_macros.svh"
module rrob_dp
    import rrob_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  item_t      s_item,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    input  logic       m_tready,
    output logic       m_tvalid,
    output result_t    m_res
);

    // latched request
    item_t item_reg;

    // control state
    logic [3:0]           bw_reg;
    logic                 admit_reg;
    logic [TAG_W-1:0]     head_reg;
    logic [TAG_W-1:0]     tail_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [ARCH_REGS-1:0] map_valid_reg;
    logic                 m_tvalid_reg;

    // stores and their registered read data
    logic [TAG_W-1:0] map_tag_mem    [ARCH_REGS];
    logic [7:0]       slot_dest_mem  [ROB_ENTRIES];
    logic             slot_ready_mem [ROB_ENTRIES];
    logic [31:0]      slot_seq_mem   [ROB_ENTRIES];
    logic [TAG_W-1:0] map_rd_a_reg;
    logic [TAG_W-1:0] map_rd_b_reg;
    logic [7:0]       sd_rd_reg;
    logic             sr_rd_reg;
    logic [31:0]      ss_rd_reg;

    result_t res_reg;
    result_t res_next;
    result_t m_res_reg;

    logic              out_free;
    logic              stall;
    logic              admit_next;
    logic              srca_ok, srcb_ok, dest_ok, sd_ok, tag_ok;
    logic [RIDX_W-1:0] srca_idx, srcb_idx, dest_idx, sd_idx, addr_a, addr_b;
    logic [TAG_W-1:0]  tag_idx;
    logic              rename_go, complete_go, retire_go, clear_go, map_we;
    logic              a_ready, b_ready;

    assign out_free      = !m_tvalid_reg || m_tready;
    assign stat.action   = cmd.load ? s_item.action : item_reg.action;
    assign stat.out_free = out_free;

    assign srca_ok  = reg_in_range(item_reg.src_a_reg);
    assign srcb_ok  = reg_in_range(item_reg.src_b_reg);
    assign dest_ok  = reg_in_range(item_reg.dest_reg);
    assign sd_ok    = reg_in_range(sd_rd_reg);
    assign srca_idx = item_reg.src_a_reg[RIDX_W-1:0];
    assign srcb_idx = item_reg.src_b_reg[RIDX_W-1:0];
    assign dest_idx = item_reg.dest_reg[RIDX_W-1:0];
    assign sd_idx   = sd_rd_reg[RIDX_W-1:0];
    assign tag_idx  = TAG_W'(item_reg.done_tag);
    assign tag_ok   = 32'(item_reg.done_tag) < ROB_ENTRIES;

    assign admit_next = (SUM_W'(occ_reg) + SUM_W'(bw_reg)) <= SUM_W'(ROB_ENTRIES);
    assign stall      = !admit_reg || (occ_reg >= OCC_W'(ROB_ENTRIES));

    assign rename_go   = cmd.eval && (item_reg.action == ACT_RENAME) && !stall;
    assign map_we      = rename_go && dest_ok;
    assign complete_go = cmd.eval && (item_reg.action == ACT_COMPLETE) && tag_ok;
    assign retire_go   = cmd.eval && (item_reg.action == ACT_RETIRE)
                         && (occ_reg != '0) && sr_rd_reg;
    // clear the mapping only while it still names the completing slot
    assign clear_go    = cmd.cmp && tag_ok && sd_ok && map_valid_reg[sd_idx]
                         && (map_rd_a_reg == tag_idx);

    // port A reads the first source, then the completing slot's destination
    assign addr_a = cmd.rd ? (srca_ok ? srca_idx : '0) : (sd_ok ? sd_idx : '0);
    assign addr_b = srcb_ok ? srcb_idx : '0;

    assign a_ready = !(srca_ok && map_valid_reg[srca_idx]);
    assign b_ready = !(srcb_ok && map_valid_reg[srcb_idx]);

    always_comb begin
        res_next = '0;
        unique case (item_reg.action)
            ACT_RENAME: begin
                if (stall) begin
                    res_next.status = ST_STALLED;
                end else begin
                    res_next.status      = ST_RENAMED;
                    res_next.slot_tag    = 6'(tail_reg);
                    res_next.src_a_ready = a_ready;
                    res_next.src_a_name  = a_ready ? item_reg.src_a_reg : 8'(map_rd_a_reg);
                    res_next.src_b_ready = b_ready;
                    res_next.src_b_name  = b_ready ? item_reg.src_b_reg : 8'(map_rd_b_reg);
                end
            end
            ACT_COMPLETE: begin
                res_next.status = ST_COMPLETED;
                if (tag_ok) begin
                    res_next.done_dest = sd_rd_reg;
                end
            end
            ACT_RETIRE: begin
                if ((occ_reg != '0) && sr_rd_reg) begin
                    res_next.status      = ST_RETIRED;
                    res_next.retired_seq = ss_rd_reg;
                end else begin
                    res_next.status = ST_NOT_READY;
                end
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    // stores
    always_ff @(posedge aclk) begin
        if (cmd.rd || cmd.eval) begin
            map_rd_a_reg <= map_tag_mem[addr_a];
        end
        if (cmd.rd) begin
            map_rd_b_reg <= map_tag_mem[addr_b];
            sd_rd_reg    <= slot_dest_mem[tag_idx];
            sr_rd_reg    <= slot_ready_mem[head_reg];
            ss_rd_reg    <= slot_seq_mem[head_reg];
        end
        if (map_we) begin
            map_tag_mem[dest_idx] <= tail_reg;
        end
        if (rename_go) begin
            slot_dest_mem[tail_reg] <= item_reg.dest_reg;
            slot_seq_mem[tail_reg]  <= item_reg.seq_number;
            slot_ready_mem[tail_reg] <= 1'b0;
        end else if (complete_go) begin
            slot_ready_mem[tag_idx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.eval) begin
            res_reg <= res_next;
        end
        if (cmd.emit) begin
            m_res_reg <= res_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg        <= BW_RESET;
            admit_reg     <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            map_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bw_reg <= cfg_wr_data;
            end
            // the admit decision is taken on the first instruction of a bundle
            if (cmd.load && (s_item.action == ACT_RENAME) && s_item.bundle_start) begin
                admit_reg <= admit_next;
            end
            if (rename_go) begin
                tail_reg <= (tail_reg == TAG_W'(ROB_ENTRIES - 1)) ? '0 : tail_reg + 1'b1;
                occ_reg  <= occ_reg + 1'b1;
            end else if (retire_go) begin
                head_reg <= (head_reg == TAG_W'(ROB_ENTRIES - 1)) ? '0 : head_reg + 1'b1;
                occ_reg  <= occ_reg - 1'b1;
            end
            if (map_we) begin
                map_valid_reg[dest_idx] <= 1'b1;
            end else if (clear_go) begin
                map_valid_reg[sd_idx] <= 1'b0;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = m_res_reg;

    `ASSERT_ALWAYS(a_occ_bound, aclk, aresetn, occ_reg <= OCC_W'(ROB_ENTRIES), "occupancy beyond buffer size")
    `ASSERT_NEVER(a_emit_blocked, aclk, aresetn, cmd.emit && !out_free, "result overwrites a pending output")
    `ASSERT_ALWAYS(a_map_set, aclk, aresetn, map_we |=> map_valid_reg[$past(dest_idx)], "rename left its destination unmapped")
    `ASSERT_ALWAYS(a_map_clear, aclk, aresetn, clear_go |=> !map_valid_reg[$past(sd_idx)], "complete left a stale mapping")

endmodule

>>> sv/register_rename_reorder_buffer.sv
// Register rename map with a circular reorder buffer. Requests carry an action:
// rename allocates a slot and reports each source as ready or by producer tag,
// complete marks a slot ready and returns its destination, retire pops the head.
// A rename or retire goes through read, evaluate and output states, a complete
// also through compare (it reads the slot's destination and then that register's
// map entry); an unused action code is dropped in idle. States follow registered
// map and slot store reads; no new request is taken until the last is through.
// A finished result sits in an output register, so a stalled output costs nothing
// until the next result is ready. Depends on rrob_pkg, rrob_ctrl and rrob_dp.
module register_rename_reorder_buffer
    import rrob_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // bundle_width
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] seq_number, [39:32] dest_reg, [47:40] src_a_reg,
    // [55:48] src_b_reg, [61:56] done_tag, [63:62] zero
    input  logic [63:0] s_tdata,
    // [1:0] action, [2] bundle_start
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] slot_tag, [6] src_a_ready, [14:7] src_a_name, [15] src_b_ready,
    // [23:16] src_b_name, [31:24] done_dest, [63:32] retired_seq
    output logic [63:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);

    item_t    s_item;
    result_t  m_res;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign s_item.action       = s_tuser[1:0];
    assign s_item.bundle_start = s_tuser[2];
    assign s_item.seq_number   = s_tdata[31:0];
    assign s_item.dest_reg     = s_tdata[39:32];
    assign s_item.src_a_reg    = s_tdata[47:40];
    assign s_item.src_b_reg    = s_tdata[55:48];
    assign s_item.done_tag     = s_tdata[61:56];

    assign m_tdata = {m_res.retired_seq, m_res.done_dest, m_res.src_b_name,
                      m_res.src_b_ready, m_res.src_a_name, m_res.src_a_ready,
                      m_res.slot_tag};
    assign m_tuser = m_res.status;

    rrob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrob_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_res       (m_res)
    );

endmodule
